// File: hdl/sktl_pkg.sv
// shared types and constants for the sorted key table lookup and insert block
package sktl_pkg;

  localparam int FONT_SLOTS_DEF  = 8;
  localparam int TABLE_DEPTH_DEF = 256;

  localparam int KEY_W  = 32;
  localparam int FONT_W = 3;
  localparam int FCNT_W = 4;
  localparam int POS_W  = 8;
  localparam int FLAG_W = 3;

  // result kinds, chosen by the controller and turned into flags by the datapath
  localparam logic [1:0] RES_HIT  = 2'd0;
  localparam logic [1:0] RES_MISS = 2'd1;
  localparam logic [1:0] RES_BAD  = 2'd2;
  localparam logic [1:0] RES_FULL = 2'd3;

  typedef struct packed {
    logic       load_req;
    logic       init_search;
    logic       probe;
    logic       narrow;
    logic       read_pos;
    logic       start_shift;
    logic       shift_step;
    logic       write_key;
    logic       res_load;
    logic [1:0] res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic lo_lt_hi;
    logic pos_lt_count;
    logic key_eq;
    logic full;
    logic shift_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/sorted_key_table_lookup_insert_top.sv
// Glyph-cache key index: each font slot keeps a sorted table of 32-bit keys (pixel size in the
// high half, character code in the low half). A request is binary-searched in its font's table;
// a hit returns the key's position, a miss inserts the key at its sorted position and returns it,
// unless the table is full. A request for a font that is not loaded is rejected. One request is
// worked on at a time. An insert inside the table first shifts the entries above the position up,
// one entry a cycle through the single key memory (one read and one write a cycle). A finished
// result waits in the output register while the next request is taken. Entry counts come up
// empty after reset with no clearing pass; key memory contents are only read below a table's count.
module sorted_key_table_lookup_insert_top #(
  parameter int FONT_SLOTS  = sktl_pkg::FONT_SLOTS_DEF,
  parameter int TABLE_DEPTH = sktl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sktl_pkg::FCNT_W-1:0] cfg_wdata,  // font_count
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sktl_pkg::KEY_W-1:0]  s_tdata,    // char_code [15:0], pixel_size [31:16]
  input  logic [sktl_pkg::FONT_W-1:0] s_tuser,    // font_index [2:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sktl_pkg::POS_W-1:0]  m_tdata,    // position [7:0]
  output logic [sktl_pkg::FLAG_W-1:0] m_tuser     // hit [0], bad_font [1], table_full [2]
);

  sktl_pkg::dp_cmd_t  cmd;
  sktl_pkg::dp_stat_t stat;

  sktl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sktl_dp #(
    .FONT_SLOTS  (FONT_SLOTS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

  // a result never overwrites one still waiting on the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> stat.out_free)
    else $error("result loaded while output word still pending");

  // one word in flight: the input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while busy");

  // at most one of hit, bad_font and table_full
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tuser))
    else $error("conflicting result flags");

  // rejected requests report position zero
  a_reject_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[1] || m_tuser[2])) |-> (m_tdata == '0))
    else $error("rejected word with non-zero position");

endmodule

// File: hdl/sktl_dp.sv
// datapath: key memory, per-font entry counts, search bounds, shift pointer, result register
module sktl_dp #(
  parameter int FONT_SLOTS  = sktl_pkg::FONT_SLOTS_DEF,
  parameter int TABLE_DEPTH = sktl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sktl_pkg::FCNT_W-1:0]   cfg_wdata,
  input  logic [sktl_pkg::KEY_W-1:0]    s_tdata,
  input  logic [sktl_pkg::FONT_W-1:0]   s_tuser,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [sktl_pkg::POS_W-1:0]    m_tdata,
  output logic [sktl_pkg::FLAG_W-1:0]   m_tuser,
  input  sktl_pkg::dp_cmd_t             cmd,
  output sktl_pkg::dp_stat_t            stat
);

  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W    = (FONT_SLOTS > 1) ? $clog2(FONT_SLOTS) : 1;
  localparam int MEM_DEPTH = FONT_SLOTS * (2 ** IDX_W);

  logic [sktl_pkg::KEY_W-1:0]  key_mem [0:MEM_DEPTH-1];
  logic [CNT_W-1:0]            cnt_mem [0:FONT_SLOTS-1];
  logic [FONT_SLOTS-1:0]       cnt_vld;

  logic [sktl_pkg::FCNT_W-1:0] font_count;
  logic [sktl_pkg::KEY_W-1:0]  key;
  logic [SLOT_W-1:0]           slot;
  logic                        bad;
  logic [CNT_W-1:0]            cnt_rd;
  logic                        cnt_rd_vld;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            lo;
  logic [CNT_W-1:0]            hi;
  logic [CNT_W-1:0]            mid_q;
  logic [CNT_W-1:0]            i_q;
  logic [IDX_W-1:0]            wr_idx;
  logic                        pend;
  logic [sktl_pkg::KEY_W-1:0]  rdata;
  logic                        out_vld;
  logic [sktl_pkg::POS_W-1:0]  out_pos;
  logic [sktl_pkg::FLAG_W-1:0] out_flags;

  logic [SLOT_W+sktl_pkg::FONT_W-1:0] font_ext;
  logic                               font_ok;
  logic [CNT_W-1:0]                   cnt_cur;
  logic [CNT_W-1:0]                   mid;
  logic [CNT_W-1:0]                   i_dec;
  logic                               i_gt_lo;
  logic                               rd_en;
  logic [IDX_W-1:0]                   rd_idx;
  logic [CNT_W+sktl_pkg::POS_W-1:0]   lo_ext;

  assign font_ext = (SLOT_W + sktl_pkg::FONT_W)'(s_tuser);
  assign font_ok  = ({1'b0, s_tuser} < font_count) && (32'(s_tuser) < 32'(FONT_SLOTS));
  assign cnt_cur  = cnt_rd_vld ? cnt_rd : '0;
  assign mid      = lo + ((hi - lo) >> 1);
  assign i_dec    = i_q - CNT_W'(1);
  assign i_gt_lo  = i_q > lo;
  assign lo_ext   = (CNT_W + sktl_pkg::POS_W)'(lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      font_count <= '0;
    end else if (cfg_we) begin
      font_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      key        <= s_tdata;
      slot       <= font_ext[SLOT_W-1:0];
      bad        <= !font_ok;
      cnt_rd     <= cnt_mem[font_ext[SLOT_W-1:0]];
      cnt_rd_vld <= cnt_vld[font_ext[SLOT_W-1:0]];
    end
    if (cmd.write_key) begin
      cnt_mem[slot] <= count + CNT_W'(1);
    end
  end

  // a slot never written reads as an empty table
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (cmd.write_key) begin
      cnt_vld[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      count <= cnt_cur;
      lo    <= '0;
      hi    <= cnt_cur;
    end else if (cmd.narrow) begin
      if (rdata < key) begin
        lo <= mid_q + CNT_W'(1);
      end else begin
        hi <= mid_q;
      end
    end
    if (cmd.probe) begin
      mid_q <= mid;
    end
  end

  // shift runs one entry a cycle: read i-1 now, write it to i next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.start_shift) begin
      pend <= 1'b0;
    end else if (cmd.shift_step) begin
      pend <= i_gt_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_shift) begin
      i_q <= count;
    end else if (cmd.shift_step && i_gt_lo) begin
      i_q    <= i_dec;
      wr_idx <= i_q[IDX_W-1:0];
    end
  end

  always_comb begin
    rd_en  = 1'b0;
    rd_idx = '0;
    if (cmd.probe) begin
      rd_en  = 1'b1;
      rd_idx = mid[IDX_W-1:0];
    end else if (cmd.read_pos) begin
      rd_en  = 1'b1;
      rd_idx = lo[IDX_W-1:0];
    end else if (cmd.shift_step && i_gt_lo) begin
      rd_en  = 1'b1;
      rd_idx = i_dec[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= key_mem[{slot, rd_idx}];
    end
    if (cmd.shift_step && pend) begin
      key_mem[{slot, wr_idx}] <= rdata;
    end else if (cmd.write_key) begin
      key_mem[{slot, lo[IDX_W-1:0]}] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.res_load) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_pos   <= (cmd.res_kind == sktl_pkg::RES_HIT || cmd.res_kind == sktl_pkg::RES_MISS)
                   ? lo_ext[sktl_pkg::POS_W-1:0] : '0;
      out_flags <= {cmd.res_kind == sktl_pkg::RES_FULL,
                    cmd.res_kind == sktl_pkg::RES_BAD,
                    cmd.res_kind == sktl_pkg::RES_HIT};
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = out_pos;
  assign m_tuser  = out_flags;

  assign stat.bad          = bad;
  assign stat.lo_lt_hi     = lo < hi;
  assign stat.pos_lt_count = lo < count;
  assign stat.key_eq       = rdata == key;
  assign stat.full         = count == CNT_W'(TABLE_DEPTH);
  assign stat.shift_done   = (i_q == lo) && !pend;
  assign stat.out_free     = !out_vld || m_tready;

endmodule

// File: hdl/sktl_ctrl.sv
// controller: sequences count fetch, binary search, hit check, shift and insert, result hand-off
module sktl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  sktl_pkg::dp_stat_t stat,
  output sktl_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CNT   = 3'd1;
  localparam logic [2:0] ST_SRCH  = 3'd2;
  localparam logic [2:0] ST_PRB   = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_MISS  = 3'd5;
  localparam logic [2:0] ST_SHIFT = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] res_kind;
  logic [1:0] res_kind_next;

  assign s_tready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      res_kind <= sktl_pkg::RES_HIT;
    end else begin
      state    <= state_next;
      res_kind <= res_kind_next;
    end
  end

  always_comb begin
    state_next    = state;
    res_kind_next = res_kind;
    cmd           = '0;
    cmd.res_kind  = res_kind;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_CNT;
        end
      end
      ST_CNT: begin
        if (stat.bad) begin
          res_kind_next = sktl_pkg::RES_BAD;
          state_next    = ST_FIN;
        end else begin
          cmd.init_search = 1'b1;
          state_next      = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (stat.lo_lt_hi) begin
          cmd.probe  = 1'b1;
          state_next = ST_PRB;
        end else if (stat.pos_lt_count) begin
          cmd.read_pos = 1'b1;
          state_next   = ST_CHK;
        end else begin
          state_next = ST_MISS;
        end
      end
      ST_PRB: begin
        cmd.narrow = 1'b1;
        state_next = ST_SRCH;
      end
      ST_CHK: begin
        if (stat.key_eq) begin
          res_kind_next = sktl_pkg::RES_HIT;
          state_next    = ST_FIN;
        end else begin
          state_next = ST_MISS;
        end
      end
      ST_MISS: begin
        if (stat.full) begin
          res_kind_next = sktl_pkg::RES_FULL;
          state_next    = ST_FIN;
        end else begin
          cmd.start_shift = 1'b1;
          state_next      = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (stat.shift_done) begin
          cmd.write_key = 1'b1;
          res_kind_next = sktl_pkg::RES_MISS;
          state_next    = ST_FIN;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: bench/tb.sv
// testbench for the sorted key table block: predicts lookup and insert results and checks each word
module tb;

  localparam int TABLE_DEPTH = sktl_pkg::TABLE_DEPTH_DEF;
  localparam int FONT_SLOTS  = sktl_pkg::FONT_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic                       hit;
    logic [sktl_pkg::POS_W-1:0] position;
    logic                       bad_font;
    logic                       table_full;
  } glyph_res_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_we    = 1'b0;
  logic [sktl_pkg::FCNT_W-1:0] cfg_wdata = '0;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [sktl_pkg::KEY_W-1:0]  s_tdata   = '0;   // char_code [15:0], pixel_size [31:16]
  logic [sktl_pkg::FONT_W-1:0] s_tuser   = '0;   // font_index [2:0]
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [sktl_pkg::POS_W-1:0]  m_tdata;          // position [7:0]
  logic [sktl_pkg::FLAG_W-1:0] m_tuser;          // hit [0], bad_font [1], table_full [2]

  sorted_key_table_lookup_insert_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  // own copy of the per-font key tables
  logic [sktl_pkg::KEY_W-1:0]  key_tbl [FONT_SLOTS][TABLE_DEPTH];
  int unsigned                 key_cnt [FONT_SLOTS];
  logic [sktl_pkg::FCNT_W-1:0] fonts_loaded = '0;

  glyph_res_t pending_results [$];
  glyph_res_t want;
  int         errors       = 0;
  int         cycles       = 0;
  bit         idle_on      = 1'b1;
  int         m_stall_left = 0;

  initial begin
    for (int f = 0; f < FONT_SLOTS; f++) key_cnt[f] = 0;
  end

  function automatic glyph_res_t lookup_insert(input logic [2:0] font,
                                               input logic [31:0] key);
    glyph_res_t r;
    int lo, hi, mid, n;
    r = '0;
    if ({1'b0, font} >= fonts_loaded) begin
      r.bad_font = 1'b1;
      return r;
    end
    n  = key_cnt[font];
    lo = 0;
    hi = n;
    // lowest index whose key is not below the request
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_tbl[font][mid] < key) lo = mid + 1;
      else hi = mid;
    end
    if (lo < n && key_tbl[font][lo] == key) begin
      r.hit      = 1'b1;
      r.position = 8'(lo);
      return r;
    end
    if (n >= TABLE_DEPTH) begin
      r.table_full = 1'b1;
      return r;
    end
    for (int i = n; i > lo; i--) key_tbl[font][i] = key_tbl[font][i-1];
    key_tbl[font][lo] = key;
    key_cnt[font]     = n + 1;
    r.position        = 8'(lo);
    return r;
  endfunction

  // mix of repeats, a crowded small key range, extremes and fully random keys
  function automatic logic [31:0] pick_key(input logic [2:0] font);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 3 && key_cnt[font] != 0)
      return key_tbl[font][$urandom_range(0, key_cnt[font] - 1)];
    if (mode < 5)
      return {14'd0, 2'($urandom_range(0, 3)), 13'd0, 3'($urandom_range(0, 7))};
    if (mode == 5)
      return {{16{1'($urandom())}}, {16{1'($urandom())}}};
    return $urandom();
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch %s: got %0d expected %0d", what, got, exp_val);
    errors++;
  endtask

  task automatic send_request(input logic [2:0] font, input logic [31:0] key);
    glyph_res_t exp_res;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= font;
    do @(posedge clk); while (!s_tready);
    exp_res         = lookup_insert(font, key);
    pending_results = {pending_results, exp_res};
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_font_count(input logic [3:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    fonts_loaded  = value;
  endtask

  task automatic test_directed();
    // nothing loaded after reset
    send_request(3'd0, 32'h0001_0041);
    send_request(3'd7, 32'hffff_ffff);
    wait_for_results();
    // count above the slot number lets every font through
    write_font_count(4'd15);
    send_request(3'd7, 32'hffff_ffff);
    send_request(3'd7, 32'h0000_0000);
    send_request(3'd7, 32'hffff_ffff);
    send_request(3'd7, 32'h0000_0000);
    send_request(3'd7, 32'h8000_7fff);
    send_request(3'd6, 32'h0000_ffff);
    wait_for_results();
    write_font_count(4'd1);
    send_request(3'd1, 32'h0010_0020);
    send_request(3'd0, 32'h0000_ffff);
    send_request(3'd0, 32'hffff_0000);
    send_request(3'd0, 32'h0010_0020);
    send_request(3'd0, 32'h0000_ffff);
    send_request(3'd0, 32'h0000_fffe);
    send_request(3'd4, 32'h0010_0020);
    wait_for_results();
    write_font_count(4'd8);
    send_request(3'd7, 32'h8000_7fff);
    send_request(3'd5, 32'h5555_aaaa);
    send_request(3'd2, 32'haaaa_5555);
    wait_for_results();
  endtask

  task automatic test_fill_table();
    int unsigned slot;
    write_font_count(4'd8);
    while (key_cnt[3] < TABLE_DEPTH) send_request(3'd3, $urandom());
    send_request(3'd3, key_tbl[3][0]);
    send_request(3'd3, key_tbl[3][TABLE_DEPTH-1]);
    slot = $urandom_range(1, TABLE_DEPTH - 2);
    send_request(3'd3, key_tbl[3][slot]);
    send_request(3'd3, 32'h0000_0000);
    send_request(3'd3, 32'hffff_ffff);
    send_request(3'd3, key_tbl[3][slot] ^ 32'h0000_0001);
    wait_for_results();
  endtask

  task automatic test_random_mix();
    int          fc_set [7] = '{8, 15, 5, -1, 8, 2, -1};
    logic [2:0]  font;
    for (int ph = 0; ph < 7; ph++) begin
      if (fc_set[ph] < 0) write_font_count(4'($urandom_range(0, 15)));
      else write_font_count(4'(fc_set[ph]));
      idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 100; n++) begin
        font = 3'($urandom_range(0, 7));
        send_request(font, pick_key(font));
      end
      wait_for_results();
    end
  endtask

  task automatic test_back_to_back();
    logic [2:0] font;
    write_font_count(4'd8);
    idle_on = 1'b0;
    for (int n = 0; n < 120; n++) begin
      font = 3'($urandom_range(0, 7));
      send_request(font, pick_key(font));
    end
    wait_for_results();
  endtask

  // result side stalls in random bursts while idle_on is set
  always @(posedge clk) begin
    if (m_stall_left != 0) begin
      m_stall_left <= m_stall_left - 1;
      m_tready     <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_stall_left <= $urandom_range(0, 10);
      m_tready     <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing expected, position", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser[0] !== want.hit) report_mismatch("hit", m_tuser[0], want.hit);
        if (m_tdata !== want.position) report_mismatch("position", m_tdata, want.position);
        if (m_tuser[1] !== want.bad_font) report_mismatch("bad_font", m_tuser[1], want.bad_font);
        if (m_tuser[2] !== want.table_full)
          report_mismatch("table_full", m_tuser[2], want.table_full);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sorted_key_table_lookup_insert_top");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_table();
    test_random_mix();
    test_back_to_back();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sorted_key_table_lookup_insert_top");
    end else begin
      $display("FAIL sorted_key_table_lookup_insert_top");
    end
    $finish;
  end

endmodule

// File: sorted_key_table_lookup_insert_top.f
hdl/sktl_pkg.sv
hdl/sktl_dp.sv
hdl/sktl_ctrl.sv
hdl/sorted_key_table_lookup_insert_top.sv
bench/tb.sv
